// ----- rtl/twof_pkg.sv -----
package twof_pkg;

  localparam int TableBitsDef = 10;
  localparam longint unsigned OneQ30 = 64'd1 << 30;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  localparam int EntryW = 18;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_WIN_LOW  = 3'd0,
    REG_WIN_HIGH = 3'd1,
    REG_INV_W    = 3'd2,
    REG_PEAK     = 3'd3,
    REG_PHASE    = 3'd4,
    REG_GROUP    = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_LO,
    MUL_HI,
    MUL_PH,
    MUL_MC,
    MUL_MP
  } mul_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MLO,
    ST_MHI,
    ST_PH,
    ST_COS,
    ST_MC,
    ST_MP,
    ST_SUM
  } state_e;

  typedef struct packed {
    logic    load;
    mul_op_e op;
    logic    lut_lo;
    logic    lut_hi;
    logic    cos;
    logic    fin;
  } cmd_t;

  typedef struct packed {
    logic in_group;
    logic out_free;
  } status_t;

  // Unsigned restoring division, evaluated only while the tables are built
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    logic [64:0]     rem;
    longint unsigned quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^(-16*v/2^30) in Q30
  function automatic longint unsigned exp_neg16(longint unsigned v);
    longint signed   sum;
    longint unsigned term;
    sum  = longint'(OneQ30);
    term = OneQ30;
    for (int n = 1; n <= 16; n++) begin
      term = udiv((term * v) >> 30, longint'(n));
      if ((n & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    for (int n = 0; n < 4; n++) begin
      sum = longint'((longint'(sum) * longint'(sum)) >> 30);
    end
    return longint'(sum);
  endfunction

  // Taylor series on one quadrant, odd selects sine
  function automatic longint signed trig_q30(longint unsigned th, bit odd);
    longint signed   sum;
    longint unsigned term;
    longint unsigned a;
    term = odd ? th : OneQ30;
    sum  = longint'(term);
    for (int n = 1; n <= 12; n++) begin
      a    = odd ? longint'(2 * n) : longint'(2 * n - 1);
      term = udiv((((term * th) >> 30) * th) >> 30, a * (a + 1));
      if ((n & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(OneQ30)) sum = longint'(OneQ30);
    return sum;
  endfunction

  function automatic longint signed q30_to_q16(longint signed x);
    longint signed r;
    if (x >= 0) r = (x + 8192) >>> 14;
    else r = -((-x + 8192) >>> 14);
    return r;
  endfunction

  function automatic longint signed tanh_entry(int k, int tb);
    longint unsigned v;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    v   = longint'(k) << (30 - tb);
    e   = exp_neg16(v);
    num = (OneQ30 - e) << 16;
    den = OneQ30 + e;
    return longint'(udiv(num + (den >> 1), den));
  endfunction

  function automatic longint signed cos_entry(int k, int tb);
    int              q;
    longint unsigned r;
    longint unsigned th;
    longint signed   c;
    longint signed   s;
    q  = k >> (tb - 2);
    r  = longint'(k) & ((longint'(1) << (tb - 2)) - 1);
    th = (r * HalfPiQ30) >> (tb - 2);
    c  = q30_to_q16(trig_q30(th, 1'b0));
    s  = q30_to_q16(trig_q30(th, 1'b1));
    case (q)
      0:       return c;
      1:       return -s;
      2:       return -c;
      default: return s;
    endcase
  endfunction

endpackage

// ----- rtl/twof_ctrl.sv -----
module twof_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  twof_pkg::status_t status_i,
  output twof_pkg::cmd_t    cmd_o
);

  twof_pkg::state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      twof_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.in_group ? twof_pkg::ST_MLO : twof_pkg::ST_SUM;
        end
      end
      twof_pkg::ST_MLO: state_d = twof_pkg::ST_MHI;
      twof_pkg::ST_MHI: state_d = twof_pkg::ST_PH;
      twof_pkg::ST_PH:  state_d = twof_pkg::ST_COS;
      twof_pkg::ST_COS: state_d = twof_pkg::ST_MC;
      twof_pkg::ST_MC:  state_d = twof_pkg::ST_MP;
      twof_pkg::ST_MP:  state_d = twof_pkg::ST_SUM;
      twof_pkg::ST_SUM: begin
        if (status_i.out_free) state_d = twof_pkg::ST_IDLE;
      end
      default: state_d = twof_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = twof_pkg::MUL_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      twof_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      twof_pkg::ST_MLO: cmd_o.op = twof_pkg::MUL_LO;
      twof_pkg::ST_MHI: begin
        cmd_o.op     = twof_pkg::MUL_HI;
        cmd_o.lut_lo = 1'b1;
      end
      twof_pkg::ST_PH: begin
        cmd_o.op     = twof_pkg::MUL_PH;
        cmd_o.lut_hi = 1'b1;
      end
      twof_pkg::ST_COS: cmd_o.cos = 1'b1;
      twof_pkg::ST_MC:  cmd_o.op = twof_pkg::MUL_MC;
      twof_pkg::ST_MP:  cmd_o.op = twof_pkg::MUL_MP;
      twof_pkg::ST_SUM: cmd_o.fin = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= twof_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/twof_datapath.sv -----
module twof_datapath #(
  parameter int TableBits = twof_pkg::TableBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic [191:0]       in_data_i,
  input  logic               in_last_i,
  output logic [175:0]       out_data_o,
  output logic               out_last_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  twof_pkg::cmd_t     cmd_i,
  output twof_pkg::status_t  status_o
);

  localparam int N = 1 << TableBits;
  localparam int EW = twof_pkg::EntryW;

  typedef logic signed [EW-1:0] tab_t [N];

  function automatic tab_t make_tanh();
    tab_t t;
    for (int k = 0; k < N; k++) t[k] = EW'(twof_pkg::tanh_entry(k, TableBits));
    return t;
  endfunction

  function automatic tab_t make_cos();
    tab_t t;
    for (int k = 0; k < N; k++) t[k] = EW'(twof_pkg::cos_entry(k, TableBits));
    return t;
  endfunction

  localparam tab_t TanhTab = make_tanh();
  localparam tab_t CosTab = make_cos();

  // Configuration registers
  logic signed [31:0] win_lo_q, win_hi_q, peak_q;
  logic [31:0]        inv_w_q, phase_q, group_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_lo_q <= '0;
      win_hi_q <= '0;
      inv_w_q  <= 32'd65536;
      peak_q   <= '0;
      phase_q  <= '0;
      group_q  <= 32'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        twof_pkg::REG_WIN_LOW:  win_lo_q <= cfg_data_i;
        twof_pkg::REG_WIN_HIGH: win_hi_q <= cfg_data_i;
        twof_pkg::REG_INV_W:    inv_w_q  <= cfg_data_i;
        twof_pkg::REG_PEAK:     peak_q   <= cfg_data_i;
        twof_pkg::REG_PHASE:    phase_q  <= cfg_data_i;
        twof_pkg::REG_GROUP:    group_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack input transaction
  logic [31:0]        in_step, in_mask;
  logic signed [31:0] in_x, in_fx, in_fy, in_fz;
  assign in_step = in_data_i[31:0];
  assign in_x    = in_data_i[63:32];
  assign in_fx   = in_data_i[95:64];
  assign in_fy   = in_data_i[127:96];
  assign in_fz   = in_data_i[159:128];
  assign in_mask = in_data_i[191:160];

  assign status_o.in_group = |(in_mask & group_q);

  logic signed [32:0] dlo, dhi;
  assign dlo = 33'(in_x) - 33'(win_lo_q);
  assign dhi = 33'(in_x) - 33'(win_hi_q);

  // Item registers
  logic [32:0]        alo_q, ahi_q;
  logic               slo_q, shi_q, grp_q, last_q;
  logic [31:0]        step1_q;
  logic signed [31:0] fx_q, fy_q, fz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      alo_q   <= dlo[32] ? 33'(-dlo) : 33'(dlo);
      ahi_q   <= dhi[32] ? 33'(-dhi) : 33'(dhi);
      slo_q   <= dlo[32];
      shi_q   <= dhi[32];
      step1_q <= in_step + 32'd1;
      fx_q    <= in_fx;
      fy_q    <= in_fy;
      fz_q    <= in_fz;
      grp_q   <= status_o.in_group;
      last_q  <= in_last_i;
    end
  end

  // Shared multiplier
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] prod_q;
  logic signed [EW-1:0] tlo_q, thi_q, c_q;
  logic signed [EW:0]   diff_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      twof_pkg::MUL_LO: begin
        mul_a = {1'b0, alo_q};
        mul_b = {1'b0, inv_w_q};
      end
      twof_pkg::MUL_HI: begin
        mul_a = {1'b0, ahi_q};
        mul_b = {1'b0, inv_w_q};
      end
      twof_pkg::MUL_PH: begin
        mul_a = {2'b00, step1_q};
        mul_b = {1'b0, phase_q};
      end
      twof_pkg::MUL_MC: begin
        mul_a = 34'(diff_q);
        mul_b = 33'(c_q);
      end
      twof_pkg::MUL_MP: begin
        mul_a = 34'(prod_q[50:17]);
        mul_b = 33'(peak_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op != twof_pkg::MUL_NONE) prod_q <= 67'(mul_a * mul_b);
  end

  // Tanh lookup on the registered magnitude product
  logic signed [EW-1:0] tmag;
  always_comb begin
    if (|prod_q[66:35]) tmag = EW'(65536);
    else tmag = TanhTab[prod_q[34:35-TableBits]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lut_lo) tlo_q <= slo_q ? -tmag : tmag;
    if (cmd_i.lut_hi) thi_q <= shi_q ? -tmag : tmag;
    if (cmd_i.cos) begin
      c_q    <= CosTab[prod_q[31:32-TableBits]];
      diff_q <= (EW+1)'(tlo_q) - (EW+1)'(thi_q);
    end
  end

  // Final add, saturation and step totals
  logic signed [35:0] nfx_wide;
  logic signed [31:0] nfx;
  logic signed [47:0] acc_x_q, acc_y_q, acc_z_q;
  logic signed [47:0] nx, ny, nz;

  function automatic logic signed [47:0] sat_add(logic signed [47:0] a,
                                                 logic signed [31:0] b);
    logic signed [48:0] s;
    s = 49'(a) + 49'(b);
    if (s[48] != s[47]) return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    return s[47:0];
  endfunction

  always_comb begin
    nfx_wide = 36'(fx_q) + 36'(signed'(prod_q[50:16]));
    if (!grp_q) nfx = fx_q;
    else if (nfx_wide > 36'sh07FFFFFFF) nfx = 32'sh7FFFFFFF;
    else if (nfx_wide < -36'sh080000000) nfx = 32'sh80000000;
    else nfx = nfx_wide[31:0];
    nx = grp_q ? sat_add(acc_x_q, nfx) : acc_x_q;
    ny = grp_q ? sat_add(acc_y_q, fy_q) : acc_y_q;
    nz = grp_q ? sat_add(acc_z_q, fz_q) : acc_z_q;
  end

  logic out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_z_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.fin) begin
        acc_x_q     <= last_q ? '0 : nx;
        acc_y_q     <= last_q ? '0 : ny;
        acc_z_q     <= last_q ? '0 : nz;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_data_o <= {nz, ny, nx, nfx};
      out_last_o <= last_q;
    end
  end

endmodule

// ----- rtl/tanh_window_oscillating_force_unit.sv -----
// Smooth-window oscillating x force with per-step force totals.
// Input stream (s_axis): one atom per transaction; tdata carries step_number,
// pos_x, force_x, force_y, force_z, group_mask; tlast marks the last atom
// of a timestep. Output stream (m_axis): one result per atom; tdata carries
// new_force_x and the 48-bit totals x, y, z; tlast is step_done.
// Configuration: cfg_valid_i/cfg_ready_o write register cfg_index_i
// (0 window_low .. 5 group_select); always ready, write only while idle.
// An atom in the selected group passes states MLO, MHI, PH, COS, MC, MP and
// SUM before its result is registered, an atom outside it goes straight to
// SUM; the steps follow the one shared 34x33 multiplier that serves the two
// tanh arguments, the phase, the window-cosine product and the peak scaling
// in turn. One atom is worked at a time, and the next waits for its result.
// A finished result waits in the output register while the next atom is
// accepted; if the receiver still stalls when that atom completes, the
// block holds it until the output register frees.
// Reset clears totals, registers to defaults and empties the output.
module tanh_window_oscillating_force_unit #(
  parameter int TableBits = twof_pkg::TableBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // step_number, pos_x, force_x, force_y, force_z, group_mask
  input  logic [191:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_force_x, total_x, total_y, total_z
  output logic [175:0] m_axis_tdata,
  output logic         m_axis_tlast
);

  twof_pkg::cmd_t    cmd;
  twof_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  twof_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  twof_datapath #(.TableBits(TableBits)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // One atom in flight at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second atom accepted while one is in flight");

  // A result appears only after an atom was being worked
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result produced without an atom in flight");

endmodule

// ----- test/tanh_window_force_checker.sv -----
// Watches the configuration, atom and result channels of the oscillating force
// unit. Keeps its own copy of the registers and step totals, predicts each
// result and compares it with what the block delivers.
module tanh_window_force_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         atom_valid_i,
  input  logic         atom_ready_i,
  input  logic [191:0] atom_data_i,
  input  logic         atom_last_i,
  input  logic         res_valid_i,
  input  logic         res_ready_i,
  input  logic [175:0] res_data_i,
  input  logic         res_last_i,
  output int           errors_o,
  output int           pending_o,
  output int           atoms_o,
  output int           in_group_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TabBits = twof_pkg::TableBitsDef;
  localparam int TabN = 1 << TabBits;
  localparam longint Q30One = longint'(1) << 30;
  localparam longint SumMax = 64'sh7FFF_FFFF_FFFF;
  localparam longint SumMin = -SumMax - 1;

  typedef struct {
    logic [31:0] force_x;
    logic [47:0] sum_x;
    logic [47:0] sum_y;
    logic [47:0] sum_z;
    logic        done;
  } force_result_t;

  force_result_t expected_forces[$];

  longint tanh_lut[TabN];
  longint cos_lut[TabN];

  logic [31:0] win_low, win_high, inv_width, peak, phase_step, group_sel;
  longint      sum_x, sum_y, sum_z;

  // e^(-16 v / 2^30) in Q30 by series and four squarings
  function automatic longint decay_q30(longint unsigned v);
    longint          acc;
    longint unsigned term;
    acc  = Q30One;
    term = longint'(Q30One);
    for (int n = 1; n <= 16; n++) begin
      term = ((term * v) >> 30) / longint'(n);
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    for (int n = 0; n < 4; n++) begin
      acc = longint'((longint'(unsigned'(acc)) * longint'(unsigned'(acc))) >> 30);
    end
    return acc;
  endfunction

  // quadrant sine or cosine series in Q30, clamped to [0, 1]
  function automatic longint quadrant_q30(longint unsigned th, bit want_sin);
    longint          acc;
    longint unsigned term;
    longint unsigned a;
    term = want_sin ? th : longint'(Q30One);
    acc  = longint'(term);
    for (int n = 1; n <= 12; n++) begin
      a    = want_sin ? longint'(2 * n) : longint'(2 * n - 1);
      term = ((((term * th) >> 30) * th) >> 30) / (a * (a + 1));
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > Q30One) acc = Q30One;
    return acc;
  endfunction

  function automatic longint round_to_q16(longint x);
    if (x >= 0) return (x + 8192) >>> 14;
    return -((-x + 8192) >>> 14);
  endfunction

  // tanh((x - win_edge) * inverse width), saturating beyond the table
  function automatic longint edge_tanh(longint x, longint win_edge);
    longint          d;
    longint unsigned ad;
    longint unsigned mag;
    longint          t;
    d   = x - win_edge;
    ad  = (d < 0) ? longint'(-d) : longint'(d);
    mag = (ad * longint'({32'b0, inv_width})) >> 16;
    if (mag >= (longint'(8) << 16)) t = 65536;
    else t = tanh_lut[(mag >> (19 - TabBits)) & (TabN - 1)];
    return (d < 0) ? -t : t;
  endfunction

  function automatic longint add_sat48(longint a, longint b);
    longint s;
    s = a + b;
    if (s > SumMax) return SumMax;
    if (s < SumMin) return SumMin;
    return s;
  endfunction

  // build both lookup tables once
  initial begin
    longint unsigned v, num, den, th;
    longint          e, c, s;
    int              q;
    for (int k = 0; k < TabN; k++) begin
      v   = longint'(k) << (30 - TabBits);
      e   = decay_q30(v);
      num = longint'(Q30One - e) << 16;
      den = longint'(Q30One + e);
      tanh_lut[k] = longint'((num + den / 2) / den);
      q  = k >> (TabBits - 2);
      th = (longint'(k & (TabN / 4 - 1)) * longint'(twof_pkg::HalfPiQ30)) >> (TabBits - 2);
      c  = round_to_q16(quadrant_q30(th, 1'b0));
      s  = round_to_q16(quadrant_q30(th, 1'b1));
      case (q)
        0:       cos_lut[k] = c;
        1:       cos_lut[k] = -s;
        2:       cos_lut[k] = -c;
        default: cos_lut[k] = s;
      endcase
    end
  end

  assign pending_o = expected_forces.size();

  // follow register writes, predict atoms, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    force_result_t   exp_r;
    logic [31:0]     step1, ph;
    longint          x, fx, nfx, diff, w, add;
    logic [191:0]    a;
    if (!rst_ni) begin
      win_low    <= '0;
      win_high   <= '0;
      inv_width  <= 32'd65536;
      peak       <= '0;
      phase_step <= '0;
      group_sel  <= 32'd1;
      sum_x = 0;
      sum_y = 0;
      sum_z = 0;
      expected_forces.delete();
      errors_o   <= 0;
      atoms_o    <= 0;
      in_group_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (twof_pkg::reg_idx_e'(cfg_index_i))
          twof_pkg::REG_WIN_LOW:  win_low    <= cfg_data_i;
          twof_pkg::REG_WIN_HIGH: win_high   <= cfg_data_i;
          twof_pkg::REG_INV_W:    inv_width  <= cfg_data_i;
          twof_pkg::REG_PEAK:     peak       <= cfg_data_i;
          twof_pkg::REG_PHASE:    phase_step <= cfg_data_i;
          twof_pkg::REG_GROUP:    group_sel  <= cfg_data_i;
          default: ;
        endcase
      end

      if (atom_valid_i && atom_ready_i) begin
        a   = atom_data_i;
        fx  = longint'(signed'(a[95:64]));
        nfx = fx;
        atoms_o <= atoms_o + 1;
        if ((a[191:160] & group_sel) != 0) begin
          in_group_o <= in_group_o + 1;
          x     = longint'(signed'(a[63:32]));
          step1 = a[31:0] + 32'd1;
          ph    = phase_step * step1;
          diff  = edge_tanh(x, longint'(signed'(win_low))) -
                  edge_tanh(x, longint'(signed'(win_high)));
          w     = (diff * cos_lut[ph >> (32 - TabBits)]) >>> 17;
          add   = (w * longint'(signed'(peak))) >>> 16;
          nfx   = fx + add;
          if (nfx > 64'sh7FFF_FFFF) nfx = 64'sh7FFF_FFFF;
          if (nfx < -64'sh8000_0000) nfx = -64'sh8000_0000;
          sum_x = add_sat48(sum_x, nfx);
          sum_y = add_sat48(sum_y, longint'(signed'(a[127:96])));
          sum_z = add_sat48(sum_z, longint'(signed'(a[159:128])));
        end
        exp_r.force_x = nfx[31:0];
        exp_r.sum_x   = sum_x[47:0];
        exp_r.sum_y   = sum_y[47:0];
        exp_r.sum_z   = sum_z[47:0];
        exp_r.done    = atom_last_i;
        expected_forces.push_back(exp_r);
        // clear totals once the step is closed
        if (atom_last_i) begin
          sum_x = 0;
          sum_y = 0;
          sum_z = 0;
        end
      end

      if (res_valid_i && res_ready_i) begin
        if (expected_forces.size() == 0) begin
          if (errors_o < 10)
            $display("unexpected result transaction: %h last %b", res_data_i, res_last_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = expected_forces.pop_front();
          if (res_data_i[31:0] !== exp_r.force_x || res_data_i[79:32] !== exp_r.sum_x ||
              res_data_i[127:80] !== exp_r.sum_y || res_data_i[175:128] !== exp_r.sum_z ||
              res_last_i !== exp_r.done) begin
            if (errors_o < 10) begin
              $display("mismatch fx exp %h got %h | sum_x exp %h got %h",
                       exp_r.force_x, res_data_i[31:0], exp_r.sum_x, res_data_i[79:32]);
              $display("  sum_y exp %h got %h | sum_z exp %h got %h | done exp %b got %b",
                       exp_r.sum_y, res_data_i[127:80], exp_r.sum_z, res_data_i[175:128],
                       exp_r.done, res_last_i);
            end
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// ----- test/tanh_window_oscillating_force_unit_test.sv -----
module tanh_window_oscillating_force_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 5000;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [175:0] m_axis_tdata;
  logic         m_axis_tlast;

  int errors, pending, atoms, in_group;
  int phases;
  int quiet_cycles;
  bit gaps_on;

  tanh_window_oscillating_force_unit dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  tanh_window_force_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .atom_valid_i(s_axis_tvalid), .atom_ready_i(s_axis_tready),
    .atom_data_i(s_axis_tdata), .atom_last_i(s_axis_tlast),
    .res_valid_i(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_data_i(m_axis_tdata), .res_last_i(m_axis_tlast),
    .errors_o(errors), .pending_o(pending), .atoms_o(atoms), .in_group_o(in_group)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // stall the result side at random
  always @(negedge clk_i) begin
    m_axis_tready <= gaps_on ? ($urandom_range(99) >= 17) : 1'b1;
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(twof_pkg::reg_idx_e idx, logic [31:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(logic [31:0] lo, logic [31:0] hi, logic [31:0] inv_w,
                           logic [31:0] pk, logic [31:0] ph, logic [31:0] grp);
    write_reg(twof_pkg::REG_WIN_LOW, lo);
    write_reg(twof_pkg::REG_WIN_HIGH, hi);
    write_reg(twof_pkg::REG_INV_W, inv_w);
    write_reg(twof_pkg::REG_PEAK, pk);
    write_reg(twof_pkg::REG_PHASE, ph);
    write_reg(twof_pkg::REG_GROUP, grp);
    phases++;
  endtask

  // drain every expected result, then let the datapath go quiet
  task automatic settle();
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_atom(logic [31:0] step, logic [31:0] x, logic [31:0] fx,
                           logic [31:0] fy, logic [31:0] fz, logic [31:0] gm,
                           logic last);
    while (gaps_on && $urandom_range(99) < 17) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {gm, fz, fy, fx, x, step};
    s_axis_tlast  = last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  initial begin
    logic [31:0] lo, hi, grp, step, x, gm;
    int          run_len;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    phases        = 0;
    gaps_on       = 1'b1;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults: zero peak, group bit 0
    send_atom(32'd0, 32'h0001_0000, 32'd100, -32'sd5, 32'd7, 32'd1, 1'b0);
    send_atom(32'd0, 32'h0, 32'd9, 32'd9, 32'd9, 32'd2, 1'b1);
    settle();

    // window around the origin, force saturation both ways
    configure(-32'sd131072, 32'sd131072, 32'h0001_0000, 32'h0005_0000,
              32'h0100_0000, 32'h3);
    send_atom(32'd0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1'b0);
    send_atom(32'd127, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h2, 1'b0);
    send_atom(32'd63, 32'h8000_0000, 32'h0, 32'h1, 32'h1, 32'hFFFF_FFFF, 1'b0);
    send_atom(32'd5, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'h1, 32'h8000_0001, 1'b0);
    send_atom(32'd9, 32'h0002_0000, 32'h1234, 32'h5, 32'h6, 32'h4, 1'b0);
    send_atom(32'd9, 32'hFFFE_0000, 32'h1234, 32'h5, 32'h6, 32'h1, 1'b1);
    send_atom(32'hFFFF_FFFF, 32'h0000_8000, 32'h0, 32'h0, 32'h0, 32'h1, 1'b1);
    settle();

    // reversed edges, all-ones mask and phase, steepest edges
    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_atom(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1'b0);
    send_atom(32'hFFFF_FFFE, 32'h8000_0000, 32'h10, 32'h0, 32'h0, 32'h8000_0000, 1'b0);
    send_atom(32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h1, 32'h0, 1'b1);
    settle();

    // empty group, flat edges, most negative peak
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h4000_0000, 32'h0);
    send_atom(32'd3, 32'h0, 32'h77, 32'h88, 32'h99, 32'hFFFF_FFFF, 1'b1);
    settle();

    // random phases, random-length steps with random content and stray tlast flips
    for (int p = 0; p < 6; p++) begin
      lo = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
      hi = lo + $urandom_range(0, 32'h0020_0000);
      if (p % 2 == 1) {lo, hi} = {hi, lo};
      grp = (p == 5) ? $urandom : (32'h1 << $urandom_range(0, 31));
      case (p)
        3:       configure(lo, hi, 32'hFFFF_FFFF, $urandom, $urandom, grp);
        4:       configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, $urandom, grp);
        default: configure(lo, hi, $urandom_range(32'h400, 32'h40_0000), $urandom,
                           $urandom, grp);
      endcase
      gaps_on = (p != 2);
      step = $urandom;
      for (int n = 0; n < 290; n += run_len) begin
        run_len = $urandom_range(1, 12);
        if ($urandom_range(99) < 3) step = 32'hFFFF_FFFF;
        for (int i = 0; i < run_len; i++) begin
          case ($urandom_range(2))
            0:       x = lo + $urandom_range(0, 32'h40_0000) - 32'h20_0000;
            1:       x = hi + $urandom_range(0, 32'h40_0000) - 32'h20_0000;
            default: x = $urandom;
          endcase
          gm = ($urandom_range(99) < 80) ? ($urandom | grp) : ($urandom & ~grp);
          send_atom(step, x, $urandom, $urandom, $urandom, gm,
                    (i == run_len - 1) ^ ($urandom_range(99) < 5));
        end
        step++;
      end
      settle();
    end

    $display("covered %0d atoms, %0d in the selected group, over %0d register settings",
             atoms, in_group, phases);
    $display("force saturation, reversed edges, phase wrap and empty group checked");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/twof_pkg.sv
rtl/twof_ctrl.sv
rtl/twof_datapath.sv
rtl/tanh_window_oscillating_force_unit.sv
test/tanh_window_force_checker.sv
test/tanh_window_oscillating_force_unit_test.sv
